FILE: rtl/core/bnr_pkg.sv
// ----------------------------------------------------------------------------
// bnr_pkg - shared definitions for the b+tree internal node router
// Field widths, operation and status codes, read address selects and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bnr_pkg;

  localparam int MAX_KEYS = 64;
  localparam int ADDR_W   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int KEY_W    = 32;
  localparam int PAGE_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;

  localparam int IN_FIELDS_W  = KEY_W + POS_W + PAGE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = PAGE_W + KEY_W + CNT_W + STAT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_FIND   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // memory read address selects
  localparam logic [2:0] RA_MID    = 3'd0;
  localparam logic [2:0] RA_LO     = 3'd1;
  localparam logic [2:0] RA_POS    = 3'd2;
  localparam logic [2:0] RA_IDX_DN = 3'd3;
  localparam logic [2:0] RA_IDX_UP = 3'd4;

  typedef struct packed {
    logic       load;
    logic       set_status;
    logic       find_init;
    logic       find_step;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       res_child_rd;
    logic       res_key_rd;
    logic       res_child_rm;
    logic       ins_init;
    logic       ins_shift;
    logic       ins_fin;
    logic       rem_init;
    logic       rem_shift;
    logic       rem_last;
    logic       cnt_dec;
    logic       wr_child;
    logic       clear;
    logic       out_load;
  } bnr_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            pos_lt_n;
    logic            pos_last;
    logic            find_open;
    logic            lo_lt_n;
    logic            ins_last;
    logic            rem_done;
    logic            out_free;
  } bnr_sts_t;

endpackage

FILE: rtl/core/bnr_dp.sv
// ----------------------------------------------------------------------------
// bnr_dp - node storage and datapath
// Key and child memories, key count, right-most child, search bounds,
// sweep index, result registers and the output register.
// ----------------------------------------------------------------------------
module bnr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bnr_pkg::bnr_cmd_t             cmd,
  output bnr_pkg::bnr_sts_t             sts,
  input  logic [bnr_pkg::OP_W-1:0]      in_op,
  input  logic [bnr_pkg::KEY_W-1:0]     in_key,
  input  logic [bnr_pkg::POS_W-1:0]     in_pos,
  input  logic [bnr_pkg::PAGE_W-1:0]    in_page,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bnr_pkg::PAGE_W-1:0]    out_child,
  output logic [bnr_pkg::KEY_W-1:0]     out_key,
  output logic [bnr_pkg::CNT_W-1:0]     out_cnt,
  output logic [bnr_pkg::STAT_W-1:0]    out_stat
);

  localparam int CW = bnr_pkg::CNT_W + 1;

  logic [bnr_pkg::KEY_W-1:0]  key_mem   [bnr_pkg::MAX_KEYS];
  logic [bnr_pkg::PAGE_W-1:0] child_mem [bnr_pkg::MAX_KEYS];

  // request fields
  logic [bnr_pkg::OP_W-1:0]   op_r;
  logic [bnr_pkg::KEY_W-1:0]  skey_r;
  logic [bnr_pkg::POS_W-1:0]  pos_r;
  logic [bnr_pkg::PAGE_W-1:0] page_r;

  // node state
  logic [bnr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bnr_pkg::PAGE_W-1:0] rm_r, rm_nxt;

  // working registers
  logic [bnr_pkg::CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [bnr_pkg::KEY_W-1:0]  key_rd_r;
  logic [bnr_pkg::PAGE_W-1:0] child_rd_r;
  logic [bnr_pkg::PAGE_W-1:0] res_child_r, res_child_nxt;
  logic [bnr_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [bnr_pkg::STAT_W-1:0] res_stat_r, res_stat_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [bnr_pkg::PAGE_W-1:0] out_child_r;
  logic [bnr_pkg::KEY_W-1:0]  out_key_r;
  logic [bnr_pkg::CNT_W-1:0]  out_cnt_r;
  logic [bnr_pkg::STAT_W-1:0] out_stat_r;

  logic [CW-1:0]                pos_x, cnt_x, idx_x, lo_x, hi_x;
  logic [CW-1:0]                mid_sum;
  logic [bnr_pkg::CNT_W-1:0]    mid, idx_dn, idx_up;
  logic                         pos_eq_n;
  logic [bnr_pkg::STAT_W-1:0]   err_code;
  logic [bnr_pkg::ADDR_W-1:0]   rd_addr;
  logic                         key_we, child_we;
  logic [bnr_pkg::ADDR_W-1:0]   key_waddr, child_waddr;
  logic [bnr_pkg::KEY_W-1:0]    key_wdata;
  logic [bnr_pkg::PAGE_W-1:0]   child_wdata;
  logic [bnr_pkg::CNT_W-1:0]    pos_inc;

  assign pos_x   = {1'b0, pos_r};
  assign cnt_x   = {1'b0, cnt_r};
  assign idx_x   = {1'b0, idx_r};
  assign lo_x    = {1'b0, lo_r};
  assign hi_x    = {1'b0, hi_r};
  assign mid_sum = lo_x + hi_x;
  assign mid     = mid_sum[CW-1:1];
  assign idx_dn  = idx_r - bnr_pkg::CNT_W'(1);
  assign idx_up  = idx_r + bnr_pkg::CNT_W'(1);
  assign pos_inc = pos_r + bnr_pkg::POS_W'(1);
  assign pos_eq_n = (pos_x == cnt_x);

  // error check for the held request
  always_comb begin
    err_code = bnr_pkg::STAT_OK;
    case (op_r)
      bnr_pkg::OP_INSERT: begin
        if (cnt_r == bnr_pkg::CNT_W'(bnr_pkg::MAX_KEYS)) err_code = bnr_pkg::STAT_FULL;
        else if (pos_x > cnt_x) err_code = bnr_pkg::STAT_RANGE;
      end
      bnr_pkg::OP_REMOVE: begin
        if (pos_x >= cnt_x) err_code = bnr_pkg::STAT_RANGE;
      end
      bnr_pkg::OP_WRITE, bnr_pkg::OP_READ: begin
        if (pos_x > cnt_x) err_code = bnr_pkg::STAT_RANGE;
      end
      default: err_code = bnr_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    sts.op        = op_r;
    sts.err       = (err_code != bnr_pkg::STAT_OK);
    sts.pos_lt_n  = (pos_x < cnt_x);
    sts.pos_last  = (pos_x + CW'(1) == cnt_x);
    sts.find_open = (lo_r < hi_r);
    sts.lo_lt_n   = (lo_r < cnt_r);
    sts.ins_last  = (idx_x == pos_x + CW'(1));
    sts.rem_done  = (idx_x + CW'(2) == cnt_x);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      bnr_pkg::RA_MID:    rd_addr = mid[bnr_pkg::ADDR_W-1:0];
      bnr_pkg::RA_LO:     rd_addr = lo_r[bnr_pkg::ADDR_W-1:0];
      bnr_pkg::RA_POS:    rd_addr = pos_r[bnr_pkg::ADDR_W-1:0];
      bnr_pkg::RA_IDX_DN: rd_addr = idx_dn[bnr_pkg::ADDR_W-1:0];
      bnr_pkg::RA_IDX_UP: rd_addr = idx_up[bnr_pkg::ADDR_W-1:0];
      default:            rd_addr = pos_r[bnr_pkg::ADDR_W-1:0];
    endcase
  end

  // memory write ports
  always_comb begin
    key_we      = 1'b0;
    key_waddr   = idx_r[bnr_pkg::ADDR_W-1:0];
    key_wdata   = key_rd_r;
    child_we    = 1'b0;
    child_waddr = idx_r[bnr_pkg::ADDR_W-1:0];
    child_wdata = child_rd_r;
    if (cmd.ins_shift) begin
      key_we   = 1'b1;
      // children move only above the split slot
      child_we = (idx_x > pos_x + CW'(1));
    end else if (cmd.rem_shift) begin
      key_we   = 1'b1;
      child_we = (idx_x > pos_x);
    end else if (cmd.ins_fin) begin
      key_we    = 1'b1;
      key_waddr = pos_r[bnr_pkg::ADDR_W-1:0];
      key_wdata = skey_r;
      child_we  = 1'b1;
      if (pos_eq_n) begin
        // old right-most child becomes the left child of the new last key
        child_waddr = pos_r[bnr_pkg::ADDR_W-1:0];
        child_wdata = rm_r;
      end else begin
        child_waddr = pos_inc[bnr_pkg::ADDR_W-1:0];
        child_wdata = page_r;
      end
    end else if (cmd.wr_child) begin
      child_we    = !pos_eq_n;
      child_waddr = pos_r[bnr_pkg::ADDR_W-1:0];
      child_wdata = page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    if (cmd.rd_en) begin
      key_rd_r   <= key_mem[rd_addr];
      child_rd_r <= child_mem[rd_addr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rm_nxt  = rm_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
      rm_nxt  = '0;
    end
    if (cmd.ins_fin) begin
      cnt_nxt = cnt_r + bnr_pkg::CNT_W'(1);
      if (pos_eq_n) rm_nxt = page_r;
    end
    if (cmd.cnt_dec) cnt_nxt = cnt_r - bnr_pkg::CNT_W'(1);
    if (cmd.rem_last) rm_nxt = child_rd_r;
    if (cmd.wr_child && pos_eq_n) rm_nxt = page_r;
  end

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    idx_nxt = idx_r;
    if (cmd.find_init) begin
      lo_nxt = '0;
      hi_nxt = cnt_r;
    end else if (cmd.find_step) begin
      // upper bound: keys equal to the search key route right
      if (key_rd_r <= skey_r) lo_nxt = mid + bnr_pkg::CNT_W'(1);
      else hi_nxt = mid;
    end
    if (cmd.ins_init) idx_nxt = cnt_r;
    else if (cmd.rem_init) idx_nxt = pos_r;
    else if (cmd.ins_shift) idx_nxt = idx_dn;
    else if (cmd.rem_shift) idx_nxt = idx_up;
  end

  always_comb begin
    res_child_nxt = res_child_r;
    res_key_nxt   = res_key_r;
    res_stat_nxt  = res_stat_r;
    if (cmd.load) begin
      res_child_nxt = '0;
      res_key_nxt   = '0;
      res_stat_nxt  = bnr_pkg::STAT_OK;
    end
    if (cmd.set_status) res_stat_nxt = err_code;
    if (cmd.res_child_rd) res_child_nxt = child_rd_r;
    if (cmd.res_child_rm) res_child_nxt = rm_r;
    if (cmd.res_key_rd) res_key_nxt = key_rd_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rm_r        <= rm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      skey_r <= in_key;
      pos_r  <= in_pos;
      page_r <= in_page;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    idx_r       <= idx_nxt;
    res_child_r <= res_child_nxt;
    res_key_r   <= res_key_nxt;
    res_stat_r  <= res_stat_nxt;
    if (cmd.out_load) begin
      out_child_r <= res_child_r;
      out_key_r   <= res_key_r;
      out_cnt_r   <= cnt_r;
      out_stat_r  <= res_stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_child = out_child_r;
  assign out_key   = out_key_r;
  assign out_cnt   = out_cnt_r;
  assign out_stat  = out_stat_r;

endmodule

FILE: rtl/core/bnr_ctrl.sv
// ----------------------------------------------------------------------------
// bnr_ctrl - request sequencer
// Steps each request through decode, search or shift sweeps and result
// hand-off, driving the datapath by command bundle.
// ----------------------------------------------------------------------------
module bnr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output bnr_pkg::bnr_cmd_t     cmd,
  input  bnr_pkg::bnr_sts_t     sts
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_FIND_RD  = 4'd2;
  localparam logic [3:0] S_FIND_CMP = 4'd3;
  localparam logic [3:0] S_FIND_CH  = 4'd4;
  localparam logic [3:0] S_INS_RD   = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_INS_FIN  = 4'd7;
  localparam logic [3:0] S_REM_RD   = 4'd8;
  localparam logic [3:0] S_REM_WR   = 4'd9;
  localparam logic [3:0] S_REM_LAST = 4'd10;
  localparam logic [3:0] S_RD_DATA  = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = bnr_pkg::RA_POS;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_DONE;
        if (!sts.err) begin
          case (sts.op)
            bnr_pkg::OP_FIND: begin
              cmd.find_init = 1'b1;
              state_nxt     = S_FIND_RD;
            end
            bnr_pkg::OP_INSERT: begin
              cmd.ins_init = 1'b1;
              state_nxt    = sts.pos_lt_n ? S_INS_RD : S_INS_FIN;
            end
            bnr_pkg::OP_REMOVE: begin
              if (sts.pos_last) begin
                // left child of the last key takes over as right-most
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bnr_pkg::RA_POS;
                state_nxt  = S_REM_LAST;
              end else begin
                cmd.rem_init = 1'b1;
                state_nxt    = S_REM_RD;
              end
            end
            bnr_pkg::OP_WRITE: begin
              cmd.wr_child = 1'b1;
            end
            bnr_pkg::OP_READ: begin
              if (sts.pos_lt_n) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bnr_pkg::RA_POS;
                state_nxt  = S_RD_DATA;
              end else begin
                cmd.res_child_rm = 1'b1;
              end
            end
            bnr_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FIND_RD: begin
        cmd.rd_en = 1'b1;
        if (sts.find_open) begin
          cmd.rd_sel = bnr_pkg::RA_MID;
          state_nxt  = S_FIND_CMP;
        end else if (sts.lo_lt_n) begin
          cmd.rd_sel = bnr_pkg::RA_LO;
          state_nxt  = S_FIND_CH;
        end else begin
          cmd.rd_en        = 1'b0;
          cmd.res_child_rm = 1'b1;
          state_nxt        = S_DONE;
        end
      end
      S_FIND_CMP: begin
        cmd.find_step = 1'b1;
        state_nxt     = S_FIND_RD;
      end
      S_FIND_CH: begin
        cmd.res_child_rd = 1'b1;
        state_nxt        = S_DONE;
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bnr_pkg::RA_IDX_DN;
        state_nxt  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_shift = 1'b1;
        state_nxt     = sts.ins_last ? S_INS_FIN : S_INS_RD;
      end
      S_INS_FIN: begin
        cmd.ins_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_REM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bnr_pkg::RA_IDX_UP;
        state_nxt  = S_REM_WR;
      end
      S_REM_WR: begin
        cmd.rem_shift = 1'b1;
        if (sts.rem_done) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_REM_RD;
        end
      end
      S_REM_LAST: begin
        cmd.rem_last = 1'b1;
        cmd.cnt_dec  = 1'b1;
        state_nxt    = S_DONE;
      end
      S_RD_DATA: begin
        cmd.res_child_rd = 1'b1;
        cmd.res_key_rd   = 1'b1;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/btree_internal_node_router.sv
// ----------------------------------------------------------------------------
// btree_internal_node_router - one b+tree internal node with routing
// Holds up to 64 sorted separator keys with their child pages and serves
// find, insert, remove, write child, read entry and clear requests.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives exactly one result. Keys and
// children live in two single-port-read memories, so every key or child
// access goes through a registered read. Find runs a binary search, each
// step a read of the middle key and a compare, then reads the chosen child
// unless the right-most child is routed. Insert and remove shift the keys
// and children at and above position p in a sweep that reads and then
// writes one key/child pair per step; removing the last key instead makes
// its left child the right-most child. A new request is taken as soon as
// the previous result sits in the output register.
module btree_internal_node_router (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // search_key, position, page_number
  input  logic [bnr_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation
  input  logic [bnr_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // child_out, key_out, key_count_out, status
  output logic [bnr_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int POS_LO  = bnr_pkg::KEY_W;
  localparam int PAGE_LO = bnr_pkg::KEY_W + bnr_pkg::POS_W;

  bnr_pkg::bnr_cmd_t            cmd;
  bnr_pkg::bnr_sts_t            sts;
  logic [bnr_pkg::PAGE_W-1:0]   out_child;
  logic [bnr_pkg::KEY_W-1:0]    out_key;
  logic [bnr_pkg::CNT_W-1:0]    out_cnt;
  logic [bnr_pkg::STAT_W-1:0]   out_stat;

  bnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bnr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_tuser),
    .in_key    (in_tdata[bnr_pkg::KEY_W-1:0]),
    .in_pos    (in_tdata[POS_LO +: bnr_pkg::POS_W]),
    .in_page   (in_tdata[PAGE_LO +: bnr_pkg::PAGE_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_child (out_child),
    .out_key   (out_key),
    .out_cnt   (out_cnt),
    .out_stat  (out_stat)
  );

  assign out_tdata = {{(bnr_pkg::OUT_DATA_W - bnr_pkg::OUT_FIELDS_W){1'b0}},
                      out_stat, out_cnt, out_key, out_child};

endmodule
